>>> rtl/lzdc_pkg.sv
// ---------------------------------------------------------------------------
// lzdc_pkg
// Types and constants shared by the LZO1Z stream decompressor modules.
// ---------------------------------------------------------------------------
package lzdc_pkg;

    localparam int CAP_W  = 24;
    localparam int DIST_W = 16;

    localparam logic [DIST_W-1:0] M1X_BASE   = 16'h0700;
    localparam logic [DIST_W-1:0] M4_BASE    = 16'h4000;
    localparam logic [4:0]        LAST_CODE  = 5'h1c;
    localparam logic [7:0]        MASK_1F    = 8'h1f;
    localparam logic [7:0]        ZERO_ADD   = 8'd255;
    localparam logic [7:0]        FIRST_BIAS = 8'd17;
    localparam logic [CAP_W-1:0]  CAP_RESET  = 24'd65536;

    typedef enum logic [2:0] {
        ST_RUNNING     = 3'd0,
        ST_FINISHED    = 3'd1,
        ST_IN_OVERRUN  = 3'd2,
        ST_OUT_OVERRUN = 3'd3,
        ST_CORRUPT     = 3'd4,
        ST_REFUSED     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_OP_LIT,
        PH_OP_AFTER_RUN,
        PH_OP_MATCH,
        PH_LEN_EXT,
        PH_LIT_RUN,
        PH_LIT_TAIL,
        PH_M1_OFF,
        PH_M1X_OFF,
        PH_M2_OFF,
        PH_OFF0,
        PH_OFF1
    } phase_t;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // one decoded item on its way to the history stage
    typedef struct packed {
        logic             wr;
        logic             is_copy;
        logic [7:0]       lit;
        logic             has_byte;
        logic             copy_pending;
        status_t          status;
        logic [CAP_W-1:0] output_count;
    } req_t;

    typedef struct packed {
        logic             has_byte;
        logic [7:0]       out_byte;
        logic             copy_pending;
        status_t          status;
        logic [CAP_W-1:0] output_count;
    } res_t;

endpackage

>>> rtl/lzdc_ifs.sv
// ---------------------------------------------------------------------------
// lzdc interfaces
// Valid/ready channels for input items, results and the capacity register.
// ---------------------------------------------------------------------------
interface lzdc_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic       end_of_input;
    modport source (output valid, kind, data_byte, end_of_input, input ready);
    modport sink (input valid, kind, data_byte, end_of_input, output ready);
endinterface

interface lzdc_out_if;
    logic        valid;
    logic        ready;
    logic        has_byte;
    logic [7:0]  out_byte;
    logic        copy_pending;
    logic [2:0]  status;
    logic [23:0] output_count;
    modport source (output valid, has_byte, out_byte, copy_pending, status, output_count,
                    input ready);
    modport sink (input valid, has_byte, out_byte, copy_pending, status, output_count,
                  output ready);
endinterface

interface lzdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> rtl/lzdc_parser.sv
// ---------------------------------------------------------------------------
// lzdc_parser
// Opcode parser and copy bookkeeping; issues history reads and writes.
// ---------------------------------------------------------------------------
module lzdc_parser
    import lzdc_pkg::*;
#(
    parameter int COUNT_BITS = 24,
    parameter int WIN_AW     = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              kind,
    input  logic [7:0]        data_byte,
    input  logic              end_of_input,
    input  logic [CAP_W-1:0]  capacity,
    output req_t              req,
    output logic [WIN_AW-1:0] waddr,
    output logic              rd_en,
    output logic [WIN_AW-1:0] raddr
);

    localparam int LEN_W = COUNT_BITS + 1;
    localparam int SUM_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 2;
    localparam logic [LEN_W-1:0] COUNT_MASK = {1'b0, {COUNT_BITS{1'b1}}};

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   run_reg, run_next;
    logic [LEN_W-1:0]   lacc_reg, lacc_next;
    logic [7:0]         cur_reg, cur_next;
    logic [DIST_W-1:0]  mdist_reg, mdist_next;
    logic [DIST_W-1:0]  last_reg, last_next;
    logic [CAP_W-1:0]   bw_reg, bw_next;
    logic [1:0]         tail_reg, tail_next;
    status_t            final_reg, final_next;

    always_comb
    begin
        logic             do_op;
        phase_t           op_mode;
        logic [7:0]       t;
        logic [7:0]       n;
        logic             complete;
        logic             mstart;
        logic [DIST_W-1:0] m_dist;
        logic [LEN_W-1:0] m_len;
        logic [1:0]       m_last;
        logic [DIST_W-1:0] d;
        logic [LEN_W:0]   lsum;
        status_t          st;
        logic             emit;

        phase_next = phase_reg;
        run_next   = run_reg;
        lacc_next  = lacc_reg;
        cur_next   = cur_reg;
        mdist_next = mdist_reg;
        last_next  = last_reg;
        bw_next    = bw_reg;
        tail_next  = tail_reg;
        final_next = final_reg;
        do_op      = 1'b0;
        op_mode    = PH_OP_LIT;
        t          = data_byte;
        n          = data_byte - FIRST_BIAS;
        complete   = 1'b0;
        mstart     = 1'b0;
        m_dist     = '0;
        m_len      = '0;
        m_last     = data_byte[1:0];
        d          = '0;
        lsum       = '0;
        emit       = 1'b0;
        st         = final_reg;
        rd_en      = 1'b0;

        if (kind == KIND_DRAIN)
        begin
            if (run_reg != '0)
            begin
                rd_en    = accept;
                run_next = run_reg - 1'b1;
                bw_next  = bw_reg + 1'b1;
            end
        end
        else if (run_reg != '0)
        begin
            st = ST_REFUSED;
        end
        else if (final_reg == ST_RUNNING)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    if (data_byte > FIRST_BIAS)
                    begin
                        if (n < 8'd4)
                        begin
                            tail_next  = n[1:0];
                            phase_next = PH_LIT_TAIL;
                        end
                        else
                        begin
                            lacc_next  = LEN_W'(n);
                            phase_next = PH_LIT_RUN;
                        end
                    end
                    else
                    begin
                        do_op = 1'b1;
                    end
                end
                PH_OP_LIT, PH_OP_AFTER_RUN, PH_OP_MATCH:
                begin
                    do_op   = 1'b1;
                    op_mode = phase_reg;
                end
                PH_LEN_EXT:
                begin
                    if (data_byte == 8'd0)
                    begin
                        lsum = {1'b0, lacc_reg} + (LEN_W+1)'(ZERO_ADD);
                        lacc_next = (lsum > (LEN_W+1)'(COUNT_MASK)) ? COUNT_MASK
                                                                    : lsum[LEN_W-1:0];
                    end
                    else if (cur_reg < 8'd16)
                    begin
                        lacc_next  = lacc_reg + LEN_W'(data_byte) + LEN_W'(18);
                        phase_next = PH_LIT_RUN;
                    end
                    else
                    begin
                        lacc_next  = lacc_reg + LEN_W'(data_byte)
                                   + ((cur_reg >= 8'd32) ? LEN_W'(31) : LEN_W'(7));
                        phase_next = PH_OFF0;
                    end
                end
                PH_LIT_RUN:
                begin
                    if (SUM_W'(bw_reg) + SUM_W'(lacc_reg) > SUM_W'(capacity))
                    begin
                        final_next = ST_OUT_OVERRUN;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        lacc_next = lacc_reg - 1'b1;
                        if (lacc_reg == LEN_W'(1))
                        begin
                            phase_next = PH_OP_AFTER_RUN;
                            complete   = 1'b1;
                        end
                    end
                end
                PH_LIT_TAIL:
                begin
                    if (SUM_W'(bw_reg) + SUM_W'(tail_reg) > SUM_W'(capacity))
                    begin
                        final_next = ST_OUT_OVERRUN;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        tail_next = tail_reg - 1'b1;
                        if (tail_reg == 2'd1)
                        begin
                            phase_next = PH_OP_MATCH;
                            complete   = 1'b1;
                        end
                    end
                end
                PH_M1_OFF:
                begin
                    mstart = 1'b1;
                    m_dist = DIST_W'(1) + DIST_W'({cur_reg[3:0], 6'd0})
                           + DIST_W'(data_byte[7:2]);
                    m_len  = LEN_W'(2);
                end
                PH_M1X_OFF:
                begin
                    mstart = 1'b1;
                    m_dist = M1X_BASE + DIST_W'(1) + DIST_W'({cur_reg[3:0], 6'd0})
                           + DIST_W'(data_byte[7:2]);
                    m_len  = LEN_W'(3);
                end
                PH_M2_OFF:
                begin
                    mstart = 1'b1;
                    m_dist = DIST_W'(1) + DIST_W'({(cur_reg & MASK_1F), 6'd0})
                           + DIST_W'(data_byte[7:2]);
                    m_len  = LEN_W'(cur_reg[7:5]) + LEN_W'(1);
                end
                PH_OFF0:
                begin
                    mdist_next = DIST_W'(data_byte);
                    phase_next = PH_OFF1;
                end
                PH_OFF1:
                begin
                    m_len = lacc_reg + LEN_W'(2);
                    if (cur_reg >= 8'd32)
                    begin
                        mstart = 1'b1;
                        m_dist = DIST_W'(1) + DIST_W'({mdist_reg[7:0], 6'd0})
                               + DIST_W'(data_byte[7:2]);
                    end
                    else
                    begin
                        d = DIST_W'({cur_reg[3], 14'd0}) + DIST_W'({mdist_reg[7:0], 6'd0})
                          + DIST_W'(data_byte[7:2]);
                        if (d == '0)
                        begin
                            final_next = ST_FINISHED;
                            complete   = 1'b1;
                        end
                        else
                        begin
                            mstart = 1'b1;
                            m_dist = d + M4_BASE;
                        end
                    end
                end
                default:
                begin
                    final_next = ST_CORRUPT;
                end
            endcase

            if (do_op)
            begin
                cur_next = t;
                if (t < 8'd16)
                begin
                    if (op_mode == PH_OP_LIT)
                    begin
                        if (t == 8'd0)
                        begin
                            lacc_next  = '0;
                            phase_next = PH_LEN_EXT;
                        end
                        else
                        begin
                            lacc_next  = LEN_W'(t) + LEN_W'(3);
                            phase_next = PH_LIT_RUN;
                        end
                    end
                    else
                    begin
                        phase_next = (op_mode == PH_OP_AFTER_RUN) ? PH_M1X_OFF : PH_M1_OFF;
                    end
                end
                else if (t >= 8'd64)
                begin
                    if (t[4:0] >= LAST_CODE)
                    begin
                        mstart = 1'b1;
                        m_dist = last_reg;
                        m_len  = LEN_W'(t[7:5]) + LEN_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_M2_OFF;
                    end
                end
                else
                begin
                    lacc_next  = (t >= 8'd32) ? LEN_W'(t[4:0]) : LEN_W'(t[2:0]);
                    phase_next = (((t >= 8'd32) ? t[4:0] : {2'b00, t[2:0]}) == 5'd0)
                               ? PH_LEN_EXT : PH_OFF0;
                end
            end

            if (mstart)
            begin
                if (m_dist == '0 || CAP_W'(m_dist) > bw_reg)
                begin
                    final_next = ST_CORRUPT;
                end
                else if (SUM_W'(bw_reg) + SUM_W'(m_len) > SUM_W'(capacity))
                begin
                    final_next = ST_OUT_OVERRUN;
                end
                else
                begin
                    mdist_next = m_dist;
                    last_next  = m_dist;
                    run_next   = m_len;
                    tail_next  = m_last;
                    phase_next = (m_last != 2'd0) ? PH_LIT_TAIL : PH_OP_LIT;
                    complete   = 1'b1;
                end
            end

            if (emit)
            begin
                bw_next = bw_reg + 1'b1;
            end

            if (end_of_input && final_next == ST_RUNNING)
            begin
                final_next = complete ? ST_FINISHED : ST_IN_OVERRUN;
            end
            st = final_next;
        end

        req.wr           = emit || (kind == KIND_DRAIN && run_reg != '0);
        req.is_copy      = (kind == KIND_DRAIN);
        req.lit          = data_byte;
        req.has_byte     = req.wr;
        req.copy_pending = (run_next != '0);
        req.status       = st;
        req.output_count = bw_next;
    end

    assign waddr = bw_reg[WIN_AW-1:0];
    assign raddr = bw_reg[WIN_AW-1:0] - WIN_AW'(mdist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            run_reg   <= '0;
            lacc_reg  <= '0;
            cur_reg   <= '0;
            mdist_reg <= '0;
            last_reg  <= '0;
            bw_reg    <= '0;
            tail_reg  <= '0;
            final_reg <= ST_RUNNING;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            run_reg   <= run_next;
            lacc_reg  <= lacc_next;
            cur_reg   <= cur_next;
            mdist_reg <= mdist_next;
            last_reg  <= last_next;
            bw_reg    <= bw_next;
            tail_reg  <= tail_next;
            final_reg <= final_next;
        end
    end

endmodule

>>> rtl/lzdc_window.sv
// ---------------------------------------------------------------------------
// lzdc_window
// History memory with the write-back stage and same-address forwarding.
// ---------------------------------------------------------------------------
module lzdc_window
    import lzdc_pkg::*;
#(
    parameter int WIN_AW = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  req_t              req,
    input  logic [WIN_AW-1:0] waddr,
    input  logic              rd_en,
    input  logic [WIN_AW-1:0] raddr,
    input  logic              advance,
    output logic              valid,
    output res_t              res
);

    logic [7:0]        window_reg [2**WIN_AW];
    logic [7:0]        rdata_reg;
    logic [7:0]        last_byte_reg;
    logic              fwd_reg;
    logic              valid_reg;
    req_t              p_reg;
    logic [WIN_AW-1:0] paddr_reg;
    logic [7:0]        byte_now;

    // a copy byte read while its source was still in this stage comes from last_byte_reg
    always_comb
    begin
        if (!p_reg.is_copy)
        begin
            byte_now = p_reg.lit;
        end
        else if (fwd_reg)
        begin
            byte_now = last_byte_reg;
        end
        else
        begin
            byte_now = rdata_reg;
        end
        res.has_byte     = p_reg.has_byte;
        res.out_byte     = p_reg.has_byte ? byte_now : 8'd0;
        res.copy_pending = p_reg.copy_pending;
        res.status       = p_reg.status;
        res.output_count = p_reg.output_count;
    end

    assign valid = valid_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= window_reg[raddr];
        end
        if (advance && p_reg.wr)
        begin
            window_reg[paddr_reg] <= byte_now;
        end
        if (advance)
        begin
            last_byte_reg <= byte_now;
        end
        if (accept)
        begin
            p_reg     <= req;
            paddr_reg <= waddr;
            fwd_reg   <= valid_reg && p_reg.wr && rd_en && (raddr == paddr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/lzo1z_stream_decompressor_top.sv
// ---------------------------------------------------------------------------
// lzo1z_stream_decompressor_top
// LZO1Z decompressor taking one compressed byte or one drain tick per cycle unless dout stalls.
// ---------------------------------------------------------------------------
// Each transaction on din is one compressed byte (kind 0) or one drain tick
// (kind 1) and yields exactly one transaction on dout when dout is ready:
// the parse stage updates state and addresses the history memory, the window
// stage reads it (registered read, same-address forwarding for overlapping
// copies) and writes the byte back, and an output register decouples dout. The block
// sustains one item per cycle unless dout stalls a full pipeline. The history memory needs
// no clearing after reset. Capacity must be written on cfg only while idle; this is not enforced.
module lzo1z_stream_decompressor_top
    import lzdc_pkg::*;
#(
    parameter int WINDOW_BYTES = 65536,
    parameter int COUNT_BITS   = 24
)
(
    input  logic       clk,
    input  logic       rst_n,
    lzdc_in_if.sink    din,
    lzdc_out_if.source dout,
    lzdc_cfg_if.sink   cfg
);

    localparam int WIN_AW = $clog2(WINDOW_BYTES);

    logic [CAP_W-1:0]  cap_reg;
    logic              accept;
    logic              advance;
    logic              p_valid;
    req_t              req;
    res_t              p_res;
    logic [WIN_AW-1:0] waddr;
    logic [WIN_AW-1:0] raddr;
    logic              rd_en;
    logic              o_valid_reg;
    res_t              o_res_reg;

    assign cfg.ready = 1'b1;
    assign advance   = p_valid && (!o_valid_reg || dout.ready);
    assign din.ready = !p_valid || advance;
    assign accept    = din.valid && din.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.data;
        end
    end

    lzdc_parser #(
        .COUNT_BITS (COUNT_BITS),
        .WIN_AW     (WIN_AW)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .kind         (din.kind),
        .data_byte    (din.data_byte),
        .end_of_input (din.end_of_input),
        .capacity     (cap_reg),
        .req          (req),
        .waddr        (waddr),
        .rd_en        (rd_en),
        .raddr        (raddr)
    );

    lzdc_window #(
        .WIN_AW (WIN_AW)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .req     (req),
        .waddr   (waddr),
        .rd_en   (rd_en),
        .raddr   (raddr),
        .advance (advance),
        .valid   (p_valid),
        .res     (p_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_res_reg <= p_res;
        end
    end

    assign dout.valid        = o_valid_reg;
    assign dout.has_byte     = o_res_reg.has_byte;
    assign dout.out_byte     = o_res_reg.out_byte;
    assign dout.copy_pending = o_res_reg.copy_pending;
    assign dout.status       = o_res_reg.status;
    assign dout.output_count = o_res_reg.output_count;

    // input stalls only when both stages are full and the sink holds off
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !din.ready |-> (dout.valid && !dout.ready))
        else $error("input stalled with room in the pipeline");

    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.has_byte) |-> (dout.out_byte == 8'd0))
        else $error("out_byte nonzero without a byte");

    a_refused_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.status == ST_REFUSED) |-> (!dout.has_byte && dout.copy_pending))
        else $error("refused transaction produced a byte or had no copy pending");

endmodule
